FILE: design/assert_macros.svh
// assertion macros shared by the biquad dry/wet block
// no dependencies; taken in by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define BQDW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// next-cycle implication, quiet while in reset
`define BQDW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: design/bqdw_pkg.sv
// shared types and constants for the biquad dry/wet block
// no dependencies
`default_nettype none

package bqdw_pkg;

    localparam int COEF_W             = 24;
    localparam int WET_W              = 17;
    localparam int HIST_W             = 32;
    localparam int ACC_W              = 60;
    localparam int MIX_SHIFT          = 16;
    localparam int APB_DATA_W         = 32;
    localparam int REG_IDX_W          = 3;
    localparam int REG_ADDR_W         = REG_IDX_W + 2;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 20;

    localparam logic [WET_W-1:0] WET_ONE = 17'h10000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_FF0,
        REG_FF1,
        REG_FF2,
        REG_FB1,
        REG_FB2,
        REG_GAIN,
        REG_DIRECT,
        REG_WET
    } bqdw_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] ff0;
        logic signed [COEF_W-1:0] ff1;
        logic signed [COEF_W-1:0] ff2;
        logic signed [COEF_W-1:0] fb1;
        logic signed [COEF_W-1:0] fb2;
        logic signed [COEF_W-1:0] gain;
        logic signed [COEF_W-1:0] direct;
        logic        [WET_W-1:0]  wet;
    } bqdw_cfg_t;

    typedef struct packed {
        logic mul_en;
        logic mul_first;
        logic mul_sub;
        logic rnd_en;
        logic rnd_mix;
    } bqdw_mac_ctl_t;

endpackage

`default_nettype wire

FILE: design/bqdw_regs.sv
// configuration register file on an apb-style port
// depends on bqdw_pkg
`default_nettype none

module bqdw_regs #(
    parameter int COEF_FRAC_BITS = bqdw_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bqdw_pkg::REG_ADDR_W-1:0]     paddr,
    input  wire logic [bqdw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [bqdw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output bqdw_pkg::bqdw_cfg_t                      cfg
);

    localparam int CW = bqdw_pkg::COEF_W;
    localparam int WW = bqdw_pkg::WET_W;
    localparam int DW = bqdw_pkg::APB_DATA_W;
    localparam int AW = bqdw_pkg::REG_ADDR_W;

    // unity in the coefficient format; zero if COEF_FRAC_BITS >= CW
    localparam logic [CW-1:0] COEF_ONE = CW'(64'd1 << COEF_FRAC_BITS);

    bqdw_pkg::bqdw_cfg_t cfg_reg;
    bqdw_pkg::bqdw_reg_t idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = bqdw_pkg::bqdw_reg_t'(paddr[AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ff0    <= COEF_ONE;
            cfg_reg.ff1    <= '0;
            cfg_reg.ff2    <= '0;
            cfg_reg.fb1    <= '0;
            cfg_reg.fb2    <= '0;
            cfg_reg.gain   <= COEF_ONE;
            cfg_reg.direct <= '0;
            cfg_reg.wet    <= bqdw_pkg::WET_ONE;
        end else if (wr_en) begin
            unique case (idx)
                bqdw_pkg::REG_FF0:    cfg_reg.ff0    <= pwdata[CW-1:0];
                bqdw_pkg::REG_FF1:    cfg_reg.ff1    <= pwdata[CW-1:0];
                bqdw_pkg::REG_FF2:    cfg_reg.ff2    <= pwdata[CW-1:0];
                bqdw_pkg::REG_FB1:    cfg_reg.fb1    <= pwdata[CW-1:0];
                bqdw_pkg::REG_FB2:    cfg_reg.fb2    <= pwdata[CW-1:0];
                bqdw_pkg::REG_GAIN:   cfg_reg.gain   <= pwdata[CW-1:0];
                bqdw_pkg::REG_DIRECT: cfg_reg.direct <= pwdata[CW-1:0];
                bqdw_pkg::REG_WET:    cfg_reg.wet    <= pwdata[WW-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            bqdw_pkg::REG_FF0:    prdata = DW'($unsigned(cfg_reg.ff0));
            bqdw_pkg::REG_FF1:    prdata = DW'($unsigned(cfg_reg.ff1));
            bqdw_pkg::REG_FF2:    prdata = DW'($unsigned(cfg_reg.ff2));
            bqdw_pkg::REG_FB1:    prdata = DW'($unsigned(cfg_reg.fb1));
            bqdw_pkg::REG_FB2:    prdata = DW'($unsigned(cfg_reg.fb2));
            bqdw_pkg::REG_GAIN:   prdata = DW'($unsigned(cfg_reg.gain));
            bqdw_pkg::REG_DIRECT: prdata = DW'($unsigned(cfg_reg.direct));
            bqdw_pkg::REG_WET:    prdata = DW'(cfg_reg.wet);
        endcase
    end

endmodule

`default_nettype wire

FILE: design/bqdw_mac.sv
// shared multiply-accumulate unit with a rounding and saturating result stage
// depends on bqdw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bqdw_mac #(
    parameter int SAMPLE_BITS    = bqdw_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = bqdw_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire bqdw_pkg::bqdw_mac_ctl_t              ctl,
    input  wire logic signed [bqdw_pkg::COEF_W-1:0]   mul_a,
    input  wire logic signed [bqdw_pkg::HIST_W-1:0]   mul_b,
    output logic signed      [bqdw_pkg::HIST_W-1:0]   res
);

    localparam int CW = bqdw_pkg::COEF_W;
    localparam int HW = bqdw_pkg::HIST_W;
    localparam int AW = bqdw_pkg::ACC_W;
    localparam int PW = CW + HW;

    localparam logic signed [AW-1:0] HALF_F   = AW'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] HALF_MIX = AW'(1) <<< (bqdw_pkg::MIX_SHIFT - 1);
    localparam logic signed [AW-1:0] HIST_MAX = (AW'(1) <<< (HW - 1)) - AW'(1);
    localparam logic signed [AW-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic signed [AW-1:0] SMP_MAX  = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] SMP_MIN  = ~SMP_MAX;

    logic signed [PW-1:0] prod_reg;
    logic                 pvalid_reg;
    logic                 pfirst_reg;
    logic                 psub_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] acc_next;
    logic signed [AW-1:0] acc_base;
    logic signed [AW-1:0] prod_ext;
    logic signed [HW-1:0] res_reg;
    logic signed [HW-1:0] res_next;
    logic signed [AW-1:0] rnd_sum;
    logic signed [AW-1:0] rnd_sh;
    logic signed [AW-1:0] sat_hi;
    logic signed [AW-1:0] sat_lo;
    logic signed [AW-1:0] sat_val;

    assign prod_ext = AW'(prod_reg);
    assign acc_base = pfirst_reg ? '0 : acc_reg;
    assign acc_next = psub_reg ? (acc_base - prod_ext) : (acc_base + prod_ext);

    // round half up, arithmetic shift, then clamp
    always_comb begin
        rnd_sum = acc_reg + (ctl.rnd_mix ? HALF_MIX : HALF_F);
        rnd_sh  = ctl.rnd_mix ? (rnd_sum >>> bqdw_pkg::MIX_SHIFT)
                              : (rnd_sum >>> COEF_FRAC_BITS);
        sat_hi  = ctl.rnd_mix ? SMP_MAX : HIST_MAX;
        sat_lo  = ctl.rnd_mix ? SMP_MIN : HIST_MIN;
        priority if (rnd_sh > sat_hi) begin
            sat_val = sat_hi;
        end else if (rnd_sh < sat_lo) begin
            sat_val = sat_lo;
        end else begin
            sat_val = rnd_sh;
        end
        res_next = HW'(sat_val);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
        end else begin
            pvalid_reg <= ctl.mul_en;
        end
        prod_reg   <= PW'(mul_a) * PW'(mul_b);
        pfirst_reg <= ctl.mul_first;
        psub_reg   <= ctl.mul_sub;
        if (pvalid_reg) begin
            acc_reg <= acc_next;
        end
        if (ctl.rnd_en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    // the accumulator must be settled when a rounding step reads it
    `BQDW_ASSERT_IMP(a_round_after_drain, aclk, aresetn, ctl.rnd_en, !pvalid_reg)

endmodule

`default_nettype wire

FILE: design/bqdw_seq.sv
// sequencer: sample and history registers, operand selection, output register
// depends on bqdw_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module bqdw_seq #(
    parameter int SAMPLE_BITS = bqdw_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic signed [SAMPLE_BITS-1:0]        s_sample,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic signed      [SAMPLE_BITS-1:0]        m_sample,
    input  wire bqdw_pkg::bqdw_cfg_t                  cfg,
    output logic signed      [bqdw_pkg::COEF_W-1:0]   mul_a,
    output logic signed      [bqdw_pkg::HIST_W-1:0]   mul_b,
    output bqdw_pkg::bqdw_mac_ctl_t                   ctl,
    input  wire logic signed [bqdw_pkg::HIST_W-1:0]   res
);

    localparam int CW = bqdw_pkg::COEF_W;
    localparam int HW = bqdw_pkg::HIST_W;
    localparam int WW = bqdw_pkg::WET_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_OUT
    } state_t;

    // an issued product passes through the product register to the accumulator
    typedef enum logic [3:0] {
        ST_A0,
        ST_A1,
        ST_A2,
        ST_B1,
        ST_B2,
        ST_WAIT1,
        ST_RND_S,
        ST_C0,
        ST_WAIT2,
        ST_RND_Y,
        ST_WET,
        ST_WAIT3,
        ST_RND_MIX
    } step_t;

    state_t                  state_reg;
    step_t                   step_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] xh1_reg;
    logic signed [SAMPLE_BITS-1:0] xh2_reg;
    logic signed [HW-1:0]    yh1_reg;
    logic signed [HW-1:0]    yh2_reg;
    logic                    m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_sample_reg;
    logic [WW-1:0]           wet_c;
    logic [WW-1:0]           dry;

    // levels above one count as fully wet
    assign wet_c = (cfg.wet > bqdw_pkg::WET_ONE) ? bqdw_pkg::WET_ONE : cfg.wet;
    assign dry   = bqdw_pkg::WET_ONE - wet_c;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_sample = m_sample_reg;

    always_comb begin
        ctl   = '0;
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_RUN) begin
            unique case (step_reg)
                ST_A0: begin
                    mul_a = cfg.ff0;
                    mul_b = HW'(x_reg);
                    ctl.mul_en    = 1'b1;
                    ctl.mul_first = 1'b1;
                end
                ST_A1: begin
                    mul_a = cfg.ff1;
                    mul_b = HW'(xh1_reg);
                    ctl.mul_en = 1'b1;
                end
                ST_A2: begin
                    mul_a = cfg.ff2;
                    mul_b = HW'(xh2_reg);
                    ctl.mul_en = 1'b1;
                end
                ST_B1: begin
                    mul_a = cfg.fb1;
                    mul_b = yh1_reg;
                    ctl.mul_en  = 1'b1;
                    ctl.mul_sub = 1'b1;
                end
                ST_B2: begin
                    mul_a = cfg.fb2;
                    mul_b = yh2_reg;
                    ctl.mul_en  = 1'b1;
                    ctl.mul_sub = 1'b1;
                end
                ST_RND_S: begin
                    // biquad sum rounds while the direct term starts a new sum
                    ctl.rnd_en    = 1'b1;
                    mul_a = cfg.direct;
                    mul_b = HW'(x_reg);
                    ctl.mul_en    = 1'b1;
                    ctl.mul_first = 1'b1;
                end
                ST_C0: begin
                    mul_a = cfg.gain;
                    mul_b = res;
                    ctl.mul_en = 1'b1;
                end
                ST_RND_Y: begin
                    ctl.rnd_en    = 1'b1;
                    mul_a = CW'(dry);
                    mul_b = HW'(x_reg);
                    ctl.mul_en    = 1'b1;
                    ctl.mul_first = 1'b1;
                end
                ST_WET: begin
                    mul_a = CW'(wet_c);
                    mul_b = res;
                    ctl.mul_en = 1'b1;
                end
                ST_RND_MIX: begin
                    ctl.rnd_en  = 1'b1;
                    ctl.rnd_mix = 1'b1;
                end
                default: begin
                    ctl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_A0;
            m_valid_reg <= 1'b0;
            xh1_reg     <= '0;
            xh2_reg     <= '0;
            yh1_reg     <= '0;
            yh2_reg     <= '0;
        end else begin
            // the output state reloads the register itself when the old result leaves
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x_reg     <= s_sample;
                        step_reg  <= ST_A0;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    // y is in the result register during this step
                    if (step_reg == ST_WET) begin
                        xh2_reg <= xh1_reg;
                        xh1_reg <= x_reg;
                        yh2_reg <= yh1_reg;
                        yh1_reg <= res;
                    end
                    if (step_reg == ST_RND_MIX) begin
                        state_reg <= S_OUT;
                    end else begin
                        step_reg <= step_t'(step_reg + 1'b1);
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_sample_reg <= res[SAMPLE_BITS-1:0];
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `BQDW_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `BQDW_ASSERT_IMP(a_result_from_done, aclk, aresetn, $rose(m_tvalid), $past(state_reg == S_OUT))

endmodule

`default_nettype wire

FILE: design/biquad_filter_dry_wet_unit.sv
// Direct form I biquad with wet/dry mix on one shared multiply-accumulate unit.
// Input samples arrive on the s_ stream (sample in the low bits of s_tdata),
// mixed results leave on the m_ stream, one result per sample, in order.
// The user must write coefficients, gains and wet level over the apb port only
// while idle; the block does not enforce it. Each sample runs a 13-step
// schedule through one 24x32 multiplier and a 60-bit accumulator: five biquad
// products, round, two gain products, round, two mix products, round.
// The output state then loads the result into the output register and raises
// m_tvalid; s_tready is low from acceptance until the result is in the output
// register, so the block takes no new sample while one is in progress.
// A stalled receiver holds the block in its output state with the result kept;
// the previous result stays on m_tdata until taken.
// Reset (aresetn low, synchronous) clears the history to zero, restores the
// register defaults (unity feedforward and biquad gain, fully wet) and drops
// m_tvalid. No clearing pass is needed; the block is ready the cycle after.
// depends on bqdw_pkg, bqdw_regs, bqdw_mac, bqdw_seq
`default_nettype none

module biquad_filter_dry_wet_unit #(
    parameter int SAMPLE_BITS    = bqdw_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = bqdw_pkg::DEF_COEF_FRAC_BITS,
    localparam int TDATA_W       = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [TDATA_W-1:0]               s_tdata,   // sample_in
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [TDATA_W-1:0]               m_tdata,   // sample_out
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bqdw_pkg::REG_ADDR_W-1:0]  paddr,
    input  wire logic [bqdw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [bqdw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    bqdw_pkg::bqdw_cfg_t                 cfg;
    bqdw_pkg::bqdw_mac_ctl_t             ctl;
    logic signed [bqdw_pkg::COEF_W-1:0]  mul_a;
    logic signed [bqdw_pkg::HIST_W-1:0]  mul_b;
    logic signed [bqdw_pkg::HIST_W-1:0]  res;
    logic signed [SAMPLE_BITS-1:0]       s_sample;
    logic signed [SAMPLE_BITS-1:0]       m_sample;

    assign s_sample = s_tdata[SAMPLE_BITS-1:0];
    assign m_tdata  = TDATA_W'($unsigned(m_sample));

    bqdw_regs #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bqdw_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .res     (res)
    );

    bqdw_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_sample),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_sample (m_sample),
        .cfg      (cfg),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .ctl      (ctl),
        .res      (res)
    );

endmodule

`default_nettype wire
